/* rtl/wats_pkg.sv */
// ----------------------------------------------------------------------------
// wats_pkg
// Shared types and constants for the weekday alarm table with snooze.
// ----------------------------------------------------------------------------
package wats_pkg;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_SNOOZE = 3'd3;
    localparam logic [2:0] ACT_TOGGLE = 3'd4;

    localparam int          MINUTES_PER_DAY = 24 * 60;
    localparam logic [10:0] NO_MINUTE       = 11'd2047;

    typedef struct packed {
        logic [10:0] minute;
        logic [6:0]  days;
        logic [10:0] snooze_len;
    } t_slot_cfg;

    typedef struct packed {
        logic cfg_we;
        logic snz_we;
    } t_mem_wr;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [10:0] now_minute;
        logic [2:0]  weekday;
        logic [10:0] alarm_minute;
        logic [6:0]  alarm_days;
        logic        alarm_on;
        logic [10:0] alarm_snooze_len;
        logic        alarm_ringing;
    } t_item;

endpackage

/* rtl/wats_slot_mem.sv */
// ----------------------------------------------------------------------------
// wats_slot_mem
// Per-slot storage: alarm settings and pending snooze minute, one write and
// one registered read per cycle for each array.
// ----------------------------------------------------------------------------
module wats_slot_mem
    import wats_pkg::*;
#(
    parameter int NUM_ALARMS = 16,
    parameter int IW         = 4
) (
    input  logic            i_clk,
    input  t_mem_wr         i_wr,
    input  logic [IW-1:0]   i_waddr,
    input  t_slot_cfg       i_wcfg,
    input  logic [10:0]     i_wsnz,
    input  logic [IW-1:0]   i_raddr,
    output t_slot_cfg       o_rcfg,
    output logic [10:0]     o_rsnz
);

    t_slot_cfg   cfg_mem [NUM_ALARMS];
    logic [10:0] snz_mem [NUM_ALARMS];

    always_ff @(posedge i_clk) begin
        if (i_wr.cfg_we) begin
            cfg_mem[i_waddr] <= i_wcfg;
        end
        o_rcfg <= cfg_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.snz_we) begin
            snz_mem[i_waddr] <= i_wsnz;
        end
        o_rsnz <= snz_mem[i_raddr];
    end

endmodule

/* rtl/weekday_alarm_table_with_snooze.sv */
// ----------------------------------------------------------------------------
// weekday_alarm_table_with_snooze
// Indexed alarm table with weekday masks, enable/playing bits and snooze.
//
// Input stream: s_axis_tuser carries the action code (tick, add, delete,
// snooze, toggle); s_axis_tdata carries slot, minute, weekday and the
// settings of an added alarm. Every input transfer yields exactly one output
// transfer on m_axis with the any_fired flag and the playing, snoozed and
// enabled masks of slots 0..15 after the item.
// Items are handled one at a time. Add, delete, toggle, unknown codes and a
// tick on an already seen minute pass through the execute and finish states.
// A snooze adds a memory read, the add and up to two mod-1440 steps. A tick
// on a new minute walks the slot memory one entry a cycle through its read
// port, from slot 0 to the last slot.
// The next item is taken while a finished result still waits in the output
// register; a stalled receiver only holds up the end of that next item.
// Reset clears all slot flags, the output valid and sets the last minute to
// the no-minute value; the slot memories are not cleared and need no pass.
// ----------------------------------------------------------------------------
module weekday_alarm_table_with_snooze
    import wats_pkg::*;
#(
    parameter int NUM_ALARMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[3:0], now_minute[14:4], weekday[17:15], alarm_minute[28:18],
    // alarm_days[35:29], alarm_on[36], alarm_snooze_len[47:37],
    // alarm_ringing[48], zero[55:49]
    input  logic [55:0] s_axis_tdata,
    // action[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // any_fired[0], playing_mask[16:1], snoozed_mask[32:17],
    // enabled_mask[48:33], zero[55:49]
    output logic [55:0] m_axis_tdata
);

    localparam int IW   = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
    localparam int MW   = (NUM_ALARMS > 16) ? NUM_ALARMS : 16;
    localparam logic [IW-1:0] LAST = IW'(NUM_ALARMS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]            r_state, n_state;
    t_item                 r_item, n_item;
    logic [10:0]           r_last, n_last;
    logic [NUM_ALARMS-1:0] r_valid, n_valid;
    logic [NUM_ALARMS-1:0] r_en, n_en;
    logic [NUM_ALARMS-1:0] r_play, n_play;
    logic [NUM_ALARMS-1:0] r_pend, n_pend;
    logic [IW-1:0]         r_idx, n_idx;
    logic [IW-1:0]         r_pidx, n_pidx;
    logic                  r_issue, n_issue;
    logic                  r_rdv, n_rdv;
    logic                  r_fired, n_fired;
    logic [11:0]           r_sum, n_sum;
    logic                  r_ov, n_ov;
    logic [55:0]           r_odata, n_odata;

    t_mem_wr       mem_wr;
    t_slot_cfg     mem_wcfg;
    t_slot_cfg     mem_rcfg;
    logic [10:0]   mem_rsnz;
    logic [IW-1:0] mem_raddr;
    logic [IW-1:0] s_idx;
    logic          addr_ok;
    logic          in_xfer;
    logic          out_free;
    logic          hit_alarm;
    logic          hit_snz;
    logic [7:0]    days_pad;
    logic [MW-1:0] play_pad, pend_pad, en_pad;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

    assign s_idx     = IW'({{IW{1'b0}}, r_item.slot});
    assign addr_ok   = {3'b000, r_item.slot} < 7'(NUM_ALARMS);
    assign mem_raddr = (r_state == S_WALK) ? r_idx : s_idx;

    assign mem_wcfg.minute     = r_item.alarm_minute;
    assign mem_wcfg.days       = r_item.alarm_days;
    assign mem_wcfg.snooze_len = r_item.alarm_snooze_len;

    assign days_pad  = {1'b0, mem_rcfg.days};
    assign hit_alarm = r_valid[r_pidx] && r_en[r_pidx] && !r_play[r_pidx]
                       && (mem_rcfg.minute == r_item.now_minute)
                       && days_pad[r_item.weekday];
    assign hit_snz   = r_pend[r_pidx] && (mem_rsnz == r_item.now_minute);

    assign play_pad = MW'(n_play);
    assign pend_pad = MW'(n_pend);
    assign en_pad   = MW'(n_en);

    wats_slot_mem #(
        .NUM_ALARMS (NUM_ALARMS),
        .IW         (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_waddr (s_idx),
        .i_wcfg  (mem_wcfg),
        .i_wsnz  (r_sum[10:0]),
        .i_raddr (mem_raddr),
        .o_rcfg  (mem_rcfg),
        .o_rsnz  (mem_rsnz)
    );

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_last  = r_last;
        n_valid = r_valid;
        n_en    = r_en;
        n_play  = r_play;
        n_pend  = r_pend;
        n_idx   = r_idx;
        n_pidx  = r_pidx;
        n_issue = r_issue;
        n_rdv   = r_rdv;
        n_fired = r_fired;
        n_sum   = r_sum;
        n_ov    = r_ov && !m_axis_tready;
        n_odata = r_odata;
        mem_wr  = '0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_item = {s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[14:4],
                              s_axis_tdata[17:15], s_axis_tdata[28:18],
                              s_axis_tdata[35:29], s_axis_tdata[36],
                              s_axis_tdata[47:37], s_axis_tdata[48]};
                    n_fired = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (r_item.action)
                    ACT_TICK: begin
                        if (r_item.now_minute != r_last) begin
                            n_last  = r_item.now_minute;
                            n_idx   = '0;
                            n_issue = 1'b1;
                            n_rdv   = 1'b0;
                            n_state = S_WALK;
                        end
                    end
                    ACT_ADD: begin
                        if (addr_ok) begin
                            mem_wr.cfg_we  = 1'b1;
                            n_valid[s_idx] = 1'b1;
                            n_en[s_idx]    = r_item.alarm_on;
                            n_play[s_idx]  = r_item.alarm_ringing;
                            n_pend[s_idx]  = 1'b0;
                        end
                    end
                    ACT_DELETE: begin
                        if (addr_ok && r_valid[s_idx]) begin
                            n_valid[s_idx] = 1'b0;
                            n_en[s_idx]    = 1'b0;
                            n_play[s_idx]  = 1'b0;
                            n_pend[s_idx]  = 1'b0;
                        end
                    end
                    ACT_SNOOZE: begin
                        if (addr_ok && r_valid[s_idx]) begin
                            n_state = S_SUM;
                        end
                    end
                    ACT_TOGGLE: begin
                        if (addr_ok && r_valid[s_idx]) begin
                            n_en[s_idx]   = !r_en[s_idx];
                            n_pend[s_idx] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                n_rdv  = r_issue;
                n_pidx = r_idx;
                if (r_issue) begin
                    if (r_idx == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_rdv) begin
                    if (hit_alarm || hit_snz) begin
                        n_play[r_pidx] = 1'b1;
                        n_fired        = 1'b1;
                    end
                    if (hit_snz) begin
                        n_pend[r_pidx] = 1'b0;
                    end
                    if (r_pidx == LAST) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SUM: begin
                n_sum   = {1'b0, r_item.now_minute} + {1'b0, mem_rcfg.snooze_len};
                n_state = S_MOD;
            end
            S_MOD: begin
                if (r_sum >= 12'(MINUTES_PER_DAY)) begin
                    n_sum = r_sum - 12'(MINUTES_PER_DAY);
                end else begin
                    mem_wr.snz_we = 1'b1;
                    n_play[s_idx] = 1'b0;
                    n_pend[s_idx] = 1'b1;
                    n_state       = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_odata = {7'b0, en_pad[15:0], pend_pad[15:0], play_pad[15:0],
                               r_fired};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= NO_MINUTE;
            r_valid <= '0;
            r_en    <= '0;
            r_play  <= '0;
            r_pend  <= '0;
            r_issue <= 1'b0;
            r_rdv   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_valid <= n_valid;
            r_en    <= n_en;
            r_play  <= n_play;
            r_pend  <= n_pend;
            r_issue <= n_issue;
            r_rdv   <= n_rdv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_idx   <= n_idx;
        r_pidx  <= n_pidx;
        r_fired <= n_fired;
        r_sum   <= n_sum;
        r_odata <= n_odata;
    end

endmodule

/* test/alarm_table_checker.sv */
// ----------------------------------------------------------------------------
// alarm_table_checker
// Watches both stream channels of the alarm table. Every input transfer is
// run through a local model of the slot table and its expected status is
// queued. Every output transfer is compared field by field with the oldest
// queued status. The mismatch count and the number of outstanding results
// are handed to the testbench top.
// ----------------------------------------------------------------------------
module alarm_table_checker
    import wats_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    // slot, now_minute, weekday, alarm_minute, alarm_days, alarm_on,
    // alarm_snooze_len, alarm_ringing, zero
    input  logic [55:0] i_in_tdata,
    // action
    input  logic [2:0]  i_in_tuser,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    // any_fired, playing_mask, snoozed_mask, enabled_mask, zero
    input  logic [55:0] i_out_tdata,
    output int          o_mismatch_count,
    output int          o_pending
);

    localparam int NUM_SLOTS   = 16;

    typedef struct packed {
        logic [15:0] enabled;
        logic [15:0] snoozed;
        logic [15:0] playing;
        logic        any_fired;
    } t_status;

    logic [NUM_SLOTS-1:0] slot_used;
    logic [NUM_SLOTS-1:0] slot_on;
    logic [NUM_SLOTS-1:0] slot_ringing;
    logic [NUM_SLOTS-1:0] snooze_armed;
    logic [10:0]          alarm_min  [NUM_SLOTS];
    logic [6:0]           alarm_mask [NUM_SLOTS];
    logic [10:0]          snooze_len [NUM_SLOTS];
    logic [10:0]          snooze_at  [NUM_SLOTS];
    logic [10:0]          last_minute;

    t_status due_status [$];
    t_status want;
    t_status actual;
    t_item   item;
    int      mismatch_count = 0;

    function automatic t_status alarm_table_step(input t_item it);
        t_status    st;
        logic [7:0] day_bit;
        logic       fired;
        int         i;
        fired   = 1'b0;
        day_bit = 8'd1 << it.weekday;
        case (it.action)
            ACT_TICK: begin
                if (it.now_minute != last_minute) begin
                    last_minute = it.now_minute;
                    for (i = 0; i < NUM_SLOTS; i++) begin
                        if (slot_used[i] && slot_on[i] && !slot_ringing[i] &&
                            alarm_min[i] == it.now_minute &&
                            |({1'b0, alarm_mask[i]} & day_bit)) begin
                            slot_ringing[i] = 1'b1;
                            fired = 1'b1;
                        end
                    end
                    for (i = 0; i < NUM_SLOTS; i++) begin
                        if (snooze_armed[i] && snooze_at[i] == it.now_minute) begin
                            slot_ringing[i] = 1'b1;
                            snooze_armed[i] = 1'b0;
                            fired = 1'b1;
                        end
                    end
                end
            end
            ACT_ADD: begin
                slot_used[it.slot]    = 1'b1;
                alarm_min[it.slot]    = it.alarm_minute;
                alarm_mask[it.slot]   = it.alarm_days;
                slot_on[it.slot]      = it.alarm_on;
                snooze_len[it.slot]   = it.alarm_snooze_len;
                slot_ringing[it.slot] = it.alarm_ringing;
                snooze_armed[it.slot] = 1'b0;
            end
            ACT_DELETE: begin
                if (slot_used[it.slot]) begin
                    slot_used[it.slot]    = 1'b0;
                    slot_on[it.slot]      = 1'b0;
                    slot_ringing[it.slot] = 1'b0;
                    snooze_armed[it.slot] = 1'b0;
                end
            end
            ACT_SNOOZE: begin
                if (slot_used[it.slot]) begin
                    slot_ringing[it.slot] = 1'b0;
                    snooze_armed[it.slot] = 1'b1;
                    snooze_at[it.slot] = 11'((int'(it.now_minute) +
                        int'(snooze_len[it.slot])) % MINUTES_PER_DAY);
                end
            end
            ACT_TOGGLE: begin
                if (slot_used[it.slot]) begin
                    slot_on[it.slot]      = ~slot_on[it.slot];
                    snooze_armed[it.slot] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        st.any_fired = fired;
        st.playing   = slot_ringing;
        st.snoozed   = snooze_armed;
        st.enabled   = slot_on;
        return st;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %h, actual %h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_used    = '0;
            slot_on      = '0;
            slot_ringing = '0;
            snooze_armed = '0;
            last_minute  = NO_MINUTE;
            due_status.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                actual = i_out_tdata[48:0];
                if (due_status.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected result: expected none, actual %h",
                             $time, actual);
                end else begin
                    want = due_status.pop_front();
                    check_field("any_fired", 16'(want.any_fired),
                                16'(actual.any_fired));
                    check_field("playing_mask", want.playing, actual.playing);
                    check_field("snoozed_mask", want.snoozed, actual.snoozed);
                    check_field("enabled_mask", want.enabled, actual.enabled);
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                item = {i_in_tuser, i_in_tdata[3:0], i_in_tdata[14:4],
                        i_in_tdata[17:15], i_in_tdata[28:18], i_in_tdata[35:29],
                        i_in_tdata[36], i_in_tdata[47:37], i_in_tdata[48]};
                due_status.push_back(alarm_table_step(item));
            end
        end
        o_pending        <= due_status.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the weekday alarm table with snooze. A directed
// pass covers minute and slot extremes, repeated ticks, weekday 7, snooze
// wrap, empty slots, overwrites and unknown actions; a random pass follows a
// running clock of day so alarms and snoozes really fire. Both stream sides
// idle at random, with one calm stretch and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top
    import wats_pkg::*;
();

    localparam int          N_RANDOM   = 800;
    localparam int          LIMIT      = 400000;
    localparam int          HOLD_AT    = 250;
    localparam int          HOLD_LEN   = 300;
    localparam int          CALM_FROM  = 420;
    localparam int          CALM_TO    = 580;
    localparam int          DRAIN      = 40;
    localparam logic [2:0]  NO_WEEKDAY = 3'd7;
    localparam logic [2:0]  ACT_LAST   = 3'd7;
    localparam logic [6:0]  ALL_DAYS   = 7'h7F;
    localparam logic [10:0] MAX_MINUTE = 11'd1439;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = ACT_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    int mismatch_count;
    int pending;
    int sent        = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;
    int clock_min;
    int cur_day;

    always #1 i_clk = ~i_clk;

    weekday_alarm_table_with_snooze #(
        .NUM_ALARMS(16)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata)
    );

    alarm_table_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_tvalid     (s_tvalid),
        .i_in_tready     (s_tready),
        .i_in_tdata      (s_tdata),
        .i_in_tuser      (s_tuser),
        .i_out_tvalid    (m_tvalid),
        .i_out_tready    (m_tready),
        .i_out_tdata     (m_tdata),
        .o_mismatch_count(mismatch_count),
        .o_pending       (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: random back-pressure plus one long hold-off
    initial begin : rx_drive
        bit held;
        int k;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (k = 1; k < HOLD_LEN; k++)
                    @(posedge i_clk);
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    function automatic t_item random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_item)-1:0];
    endfunction

    task automatic send_item(input t_item it);
        while (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tdata  <= {7'd0, it.alarm_ringing, it.alarm_snooze_len, it.alarm_on,
                     it.alarm_days, it.alarm_minute, it.weekday, it.now_minute,
                     it.slot};
        do @(posedge i_clk); while (!s_tready);
        sent++;
    endtask

    task automatic send_op(input logic [2:0] act, input logic [3:0] slot,
                           input logic [10:0] now, input logic [2:0] wday);
        t_item it;
        it            = random_item();
        it.action     = act;
        it.slot       = slot;
        it.now_minute = now;
        it.weekday    = wday;
        send_item(it);
    endtask

    task automatic send_add(input logic [3:0] slot, input logic [10:0] minute,
                            input logic [6:0] days, input logic on,
                            input logic [10:0] len, input logic ring);
        t_item it;
        it                  = random_item();
        it.action           = ACT_ADD;
        it.slot             = slot;
        it.alarm_minute     = minute;
        it.alarm_days       = days;
        it.alarm_on         = on;
        it.alarm_snooze_len = len;
        it.alarm_ringing    = ring;
        send_item(it);
    endtask

    initial begin : stimulus
        t_item it;
        int    n;
        int    r;
        int    c;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        send_op(ACT_TICK, 4'd0, NO_MINUTE, 3'd0);
        send_add(4'd0, 11'd0, ALL_DAYS, 1'b1, 11'd0, 1'b0);
        send_add(4'd15, MAX_MINUTE, 7'h01, 1'b1, MAX_MINUTE, 1'b1);
        send_op(ACT_TICK, 4'd3, 11'd0, 3'd0);
        send_op(ACT_TICK, 4'd9, 11'd0, 3'd0);
        send_op(ACT_SNOOZE, 4'd0, 11'd0, 3'd2);
        send_op(ACT_TICK, 4'd1, MAX_MINUTE, 3'd0);
        send_op(ACT_SNOOZE, 4'd15, MAX_MINUTE, 3'd5);
        send_op(ACT_TICK, 4'd2, 11'd1438, 3'd3);
        send_op(ACT_TICK, 4'd4, 11'd0, NO_WEEKDAY);
        send_op(ACT_TOGGLE, 4'd0, 11'd5, 3'd1);
        send_op(ACT_SNOOZE, 4'd0, NO_MINUTE, 3'd6);
        send_op(ACT_TOGGLE, 4'd0, 11'd7, 3'd4);
        send_op(ACT_DELETE, 4'd0, 11'd0, 3'd0);
        send_op(ACT_DELETE, 4'd0, 11'd0, 3'd0);
        send_op(ACT_SNOOZE, 4'd3, 11'd100, 3'd0);
        send_op(ACT_TOGGLE, 4'd3, 11'd100, 3'd0);
        send_op(ACT_TOGGLE + 3'd1, 4'd15, MAX_MINUTE, 3'd0);
        send_op(ACT_TOGGLE + 3'd2, 4'd15, NO_MINUTE, NO_WEEKDAY);
        send_op(ACT_LAST, 4'd15, 11'd0, 3'd0);
        send_op(ACT_SNOOZE, 4'd15, 11'd100, 3'd0);
        send_add(4'd15, 11'd101, ALL_DAYS, 1'b1, 11'd1, 1'b0);
        send_add(4'd7, NO_MINUTE, 7'h00, 1'b0, 11'd2047, 1'b1);
        send_op(ACT_TOGGLE, 4'd7, 11'd0, 3'd0);
        send_op(ACT_SNOOZE, 4'd7, NO_MINUTE, 3'd0);
        send_op(ACT_TICK, 4'd0, 11'd1214, 3'd2);
        send_op(ACT_TICK, 4'd0, NO_MINUTE, NO_WEEKDAY);

        // random, following a running clock of day
        clock_min = $urandom_range(0, 1439);
        cur_day   = $urandom_range(0, 6);
        for (n = 0; n < N_RANDOM; n++) begin
            calm    = (n >= CALM_FROM) && (n < CALM_TO);
            it      = random_item();
            it.slot = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 5))
                                                   : 4'($urandom);
            r = $urandom_range(0, 99);
            if (r < 45) begin
                it.action = ACT_TICK;
                c = $urandom_range(0, 99);
                if (c < 75) begin
                    clock_min = (clock_min + 1) % MINUTES_PER_DAY;
                    if (clock_min == 0)
                        cur_day = (cur_day + 1) % 7;
                end else if (c >= 85 && c < 95) begin
                    clock_min = $urandom_range(0, 1439);
                end
                it.now_minute = (c >= 95) ? 11'($urandom) : 11'(clock_min);
                if ($urandom_range(0, 99) >= 10)
                    it.weekday = 3'(cur_day);
            end else if (r < 62) begin
                it.action = ACT_ADD;
                if ($urandom_range(0, 99) < 85)
                    it.alarm_minute = 11'((clock_min + $urandom_range(1, 15)) %
                                          MINUTES_PER_DAY);
                c = $urandom_range(0, 99);
                if (c < 40)
                    it.alarm_days = ALL_DAYS;
                else if (c < 70)
                    it.alarm_days = 7'(1 << cur_day);
                it.alarm_on = ($urandom_range(0, 99) < 85);
                if ($urandom_range(0, 99) < 85)
                    it.alarm_snooze_len = 11'($urandom_range(0, 8));
                it.alarm_ringing = ($urandom_range(0, 99) < 15);
            end else if (r < 78) begin
                it.action = ACT_SNOOZE;
                if ($urandom_range(0, 99) < 90)
                    it.now_minute = 11'(clock_min);
            end else if (r < 88) begin
                it.action = ACT_TOGGLE;
            end else if (r < 96) begin
                it.action = ACT_DELETE;
            end else begin
                it.action = 3'($urandom_range(ACT_TOGGLE + 1, ACT_LAST));
            end
            send_item(it);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
